### design/awba_pkg.sv
// shared constants and types for the aligned window bump allocator
`default_nettype none

package awba_pkg;

    localparam int POOL_COUNT = 4;
    localparam int POOL_IDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_NO_SPACE = 2'd3;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] remaining;
    } win_t;

    typedef struct packed {
        logic                  en;
        logic [POOL_IDX_W-1:0] idx;
        win_t                  data;
    } win_wr_t;

endpackage

`default_nettype wire

### design/awba_req_if.sv
// request channel interface of the allocator
`default_nettype none

interface awba_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [2:0]  pool_type;
    logic [63:0] address;
    logic [63:0] length;
    logic [5:0]  align_log2;

    modport source (
        output valid, command, pool_type, address, length, align_log2,
        input  ready
    );
    modport sink (
        input  valid, command, pool_type, address, length, align_log2,
        output ready
    );
endinterface

`default_nettype wire

### design/awba_rsp_if.sv
// response channel interface of the allocator
`default_nettype none

interface awba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] granted_address;

    modport source (
        output valid, status, granted_address,
        input  ready
    );
    modport sink (
        input  valid, status, granted_address,
        output ready
    );
endinterface

`default_nettype wire

### design/awba_win_ram.sv
// window store: synchronous ram of start and remaining per pool type
`default_nettype none

module awba_win_ram import awba_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [POOL_IDX_W-1:0] rd_idx,
    output win_t                       rd_data,
    input  wire win_wr_t               wr
);

    win_t                  mem [POOL_COUNT];
    win_t                  rd_q_reg;
    logic [POOL_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_idx];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

### design/aligned_window_bump_allocator.sv
// top level: request sequencer and alignment datapath around the window ram
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    command, pool_type, address, length, align_log2
//  rsp      out  valid/ready    status, granted_address
//
// each request steps through accept, ram read, span, update and respond
// the registered ram read and the split add / compare chain set these steps
// a new request is accepted while the previous response waits in its register
// if the response register is still full, the update step holds until it drains
// rst_n clears the sequencer, the response valid and the ram entry valid bits
`default_nettype none

module aligned_window_bump_allocator import awba_pkg::*; (
    input wire logic   clk,
    input wire logic   rst_n,
    awba_req_if.sink   req,
    awba_rsp_if.source rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;

    logic                  cmd_reg;
    logic [POOL_IDX_W-1:0] idx_reg;
    logic [63:0]           addr_reg;
    logic [63:0]           len_reg;
    logic [63:0]           mask_reg;
    logic                  bad_reg;
    logic [63:0]           old_reg;
    logic [63:0]           end_raw_reg;
    logic [63:0]           astart_reg;
    logic [63:0]           aend_reg;
    logic [63:0]           span_reg;
    logic                  crossed_reg;
    logic [63:0]           new_start_reg;

    logic                  rsp_valid_reg;
    logic [1:0]            status_reg;
    logic [63:0]           grant_reg;

    logic                  req_fire;
    logic                  type_ok;
    logic                  rsp_free;
    logic                  fin_go;
    logic [63:0]           rd_end;
    logic [64:0]           span_diff;
    logic [1:0]            status_fin;
    logic [63:0]           grant_fin;
    win_t                  rd_data;
    win_wr_t               wr;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign type_ok   = ({1'b0, req.pool_type} < 4'(POOL_COUNT));
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign fin_go    = (state_reg == S_FIN) && rsp_free;

    awba_win_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (req_fire && type_ok),
        .rd_idx  (req.pool_type[POOL_IDX_W-1:0]),
        .rd_data (rd_data),
        .wr      (wr)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (req_fire) state_next = S_READ;
            S_READ:  state_next = S_CALC;
            S_CALC:  state_next = S_FIN;
            S_FIN:   if (rsp_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture and alignment datapath
    assign rd_end    = rd_data.start + rd_data.remaining;
    assign span_diff = {1'b0, aend_reg} - {1'b0, astart_reg};

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg  <= req.command;
            idx_reg  <= req.pool_type[POOL_IDX_W-1:0];
            addr_reg <= req.address;
            len_reg  <= req.length;
            mask_reg <= (64'd1 << req.align_log2) - 64'd1;
            if (req.command == CMD_INSERT)
            begin
                bad_reg <= !type_ok || (req.address == 64'd0) || (req.length == 64'd0);
            end
            else
            begin
                bad_reg <= !type_ok || (req.length == 64'd0);
            end
        end
        if (state_reg == S_READ)
        begin
            old_reg     <= rd_data.start;
            end_raw_reg <= rd_end;
            astart_reg  <= (rd_data.start + mask_reg) & ~mask_reg;
            aend_reg    <= rd_end & ~mask_reg;
        end
        if (state_reg == S_CALC)
        begin
            span_reg      <= span_diff[63:0];
            crossed_reg   <= span_diff[64];
            new_start_reg <= astart_reg + len_reg;
        end
    end

    // decision, write back and response
    always_comb
    begin
        status_fin    = ST_OK;
        grant_fin     = 64'd0;
        wr.en         = 1'b0;
        wr.idx        = idx_reg;
        wr.data.start = addr_reg;
        wr.data.remaining = len_reg;
        priority if (bad_reg)
        begin
            status_fin = ST_INVALID;
        end
        else if (cmd_reg == CMD_INSERT)
        begin
            if (old_reg != 64'd0)
            begin
                status_fin = ST_INSERTED;
            end
            else
            begin
                wr.en = fin_go;
            end
        end
        else if (crossed_reg || (span_reg < len_reg))
        begin
            status_fin = ST_NO_SPACE;
        end
        else
        begin
            grant_fin         = astart_reg;
            wr.en             = fin_go;
            wr.data.start     = new_start_reg;
            wr.data.remaining = end_raw_reg - new_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            status_reg <= status_fin;
            grant_reg  <= grant_fin;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.granted_address = grant_reg;

    a_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_FIN) && (status_fin == ST_OK))
        else $error("window write outside the update step");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_READ) && !req.ready)
        else $error("accepted request did not start the ram read");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> rsp.valid && (state_reg == S_IDLE))
        else $error("response not loaded at end of request");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go && (status_fin != ST_OK) |=> (rsp.granted_address == 64'd0))
        else $error("nonzero grant on a failed request");

endmodule

`default_nettype wire
